[rtl/sje_pkg.sv]
`default_nettype none
package sje_pkg;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_SQRT = 2'd1,
      ALU_DIV  = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   localparam logic [1:0] CSR_MAX_SWEEPS = 2'd0;
   localparam logic [1:0] CSR_CONVERGE   = 2'd1;
   localparam logic [1:0] CSR_FLOOR      = 2'd2;

   localparam logic [7:0] MAX_SWEEPS_RST = 8'd100;
   localparam logic [5:0] DIV12          = 6'd12;

   // floor(x / 12) = (x * RECIP12) >> RECIP12_SH for any 64-bit x
   localparam logic [63:0] RECIP12    = 64'hAAAA_AAAA_AAAA_AAAB;
   localparam int          RECIP12_SH = 67;

   function automatic logic signed [63:0] sat_w(input logic signed [63:0] x, input int w);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic signed [63:0] mulr_fin(input logic [127:0] p, input logic neg,
                                                   input int sh);
      logic [127:0] t;
      logic [63:0]  m;
      t = (p + (128'd1 << (sh - 1))) >> sh;
      m = (t[127:64] != 64'd0) ? '1 : t[63:0];
      if (m[63]) m = {1'b0, {63{1'b1}}};
      return neg ? -$signed(m) : $signed(m);
   endfunction

endpackage
`default_nettype wire

[rtl/sje_alu.sv]
`default_nettype none
module sje_alu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sje_pkg::alu_req_type req,
   input  wire logic [127:0]         opa,
   input  wire logic [63:0]          opb,
   output logic      [127:0]         res,
   output logic                      done
);

   typedef enum logic [1:0] {
      AS_IDLE = 2'b01,
      AS_RUN  = 2'b10
   } alu_state_type;

   alu_state_type       st_ff, st_in;
   sje_pkg::alu_op_type op_ff, op_in;
   logic [6:0]          cnt_ff, cnt_in, last;
   logic [127:0]        acc_ff, acc_in;
   logic [63:0]         ma_ff, ma_in, mb_ff, mb_in;
   logic [65:0]         rem_ff, rem_in;
   logic                over_ff, over_in, dz_ff, dz_in, done_ff, done_in;
   logic [71:0]         part;
   logic [67:0]         remx, trial;
   logic [64:0]         r2;

   always_comb begin
      unique case (op_ff)
         sje_pkg::ALU_MUL:  last = 7'd7;
         sje_pkg::ALU_SQRT: last = 7'd63;
         default:           last = 7'd127;
      endcase
   end

   always_comb begin
      part  = ma_ff * mb_ff[63:56];
      remx  = {rem_ff, acc_ff[127:126]};
      trial = {2'b00, mb_ff, 2'b01};
      r2    = {rem_ff[63:0], acc_ff[127]};
      st_in   = st_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      rem_in  = rem_ff;
      over_in = over_ff;
      dz_in   = dz_ff;
      done_in = 1'b0;
      unique case (st_ff)
         AS_IDLE: begin
            if (req.start) begin
               st_in   = AS_RUN;
               op_in   = req.op;
               cnt_in  = '0;
               rem_in  = '0;
               over_in = 1'b0;
               dz_in   = (opb == 64'd0);
               acc_in  = (req.op == sje_pkg::ALU_MUL) ? 128'd0 : opa;
               ma_in   = (req.op == sje_pkg::ALU_MUL) ? opa[63:0] : opb;
               mb_in   = (req.op == sje_pkg::ALU_MUL) ? opb : 64'd0;
            end
         end
         AS_RUN: begin
            case (op_ff)
               sje_pkg::ALU_MUL: begin
                  acc_in = (acc_ff << 8) + 128'(part);
                  mb_in  = mb_ff << 8;
               end
               sje_pkg::ALU_SQRT: begin
                  acc_in = acc_ff << 2;
                  if (remx >= trial) begin
                     rem_in = 66'(remx - trial);
                     mb_in  = {mb_ff[62:0], 1'b1};
                  end else begin
                     rem_in = remx[65:0];
                     mb_in  = {mb_ff[62:0], 1'b0};
                  end
               end
               default: begin
                  acc_in = acc_ff << 1;
                  if (r2 >= {1'b0, ma_ff}) begin
                     rem_in = {2'b00, 64'(r2 - {1'b0, ma_ff})};
                     mb_in  = {mb_ff[62:0], 1'b1};
                     if (!cnt_ff[6]) over_in = 1'b1;
                  end else begin
                     rem_in = {2'b00, r2[63:0]};
                     mb_in  = {mb_ff[62:0], 1'b0};
                  end
               end
            endcase
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == last) begin
               st_in   = AS_IDLE;
               done_in = 1'b1;
            end
         end
         default: st_in = AS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= AS_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      rem_ff  <= rem_in;
      over_ff <= over_in;
      dz_ff   <= dz_in;
   end

   always_comb begin
      unique case (op_ff)
         sje_pkg::ALU_MUL:  res = acc_ff;
         sje_pkg::ALU_SQRT: res = {64'd0, mb_ff};
         default:           res = {64'd0, (over_ff || dz_ff) ? 64'hFFFF_FFFF_FFFF_FFFF : mb_ff};
      endcase
   end

   assign done = done_ff;

endmodule
`default_nettype wire

[rtl/symmetric_3x3_jacobi_eigen.sv]
`default_nettype none
// channel   | handshake            | payload
// request   | start in, busy out   | req_a_xx .. req_a_yz
// response  | rsp_valid out        | rsp_lambda_0..2, rsp_vec0_x .. rsp_vec2_z
// csr       | csr_we in            | csr_addr, csr_wdata
// One request runs a sequence of sweeps, each with up to three rotations, on one shared unit;
// the bit-serial divider (128 steps) and square root (64 steps) dominate its run time.
// Reset clears the sequencer and loads register defaults.
// busy stays high from acceptance until the cycle after rsp_valid.
// The response lasts one cycle; the receiver cannot stall it.
module symmetric_3x3_jacobi_eigen #(
   parameter int WORD_BITS            = 32,
   parameter int VALUE_FRACTION_BITS  = 24,
   parameter int VECTOR_FRACTION_BITS = 30
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [WORD_BITS-1:0] req_a_xx,
   input  wire logic signed [WORD_BITS-1:0] req_a_yy,
   input  wire logic signed [WORD_BITS-1:0] req_a_zz,
   input  wire logic signed [WORD_BITS-1:0] req_a_xy,
   input  wire logic signed [WORD_BITS-1:0] req_a_xz,
   input  wire logic signed [WORD_BITS-1:0] req_a_yz,
   output logic                             rsp_valid,
   output logic signed [WORD_BITS-1:0]      rsp_lambda_0,
   output logic signed [WORD_BITS-1:0]      rsp_lambda_1,
   output logic signed [WORD_BITS-1:0]      rsp_lambda_2,
   output logic signed [WORD_BITS-1:0]      rsp_vec0_x,
   output logic signed [WORD_BITS-1:0]      rsp_vec0_y,
   output logic signed [WORD_BITS-1:0]      rsp_vec0_z,
   output logic signed [WORD_BITS-1:0]      rsp_vec1_x,
   output logic signed [WORD_BITS-1:0]      rsp_vec1_y,
   output logic signed [WORD_BITS-1:0]      rsp_vec1_z,
   output logic signed [WORD_BITS-1:0]      rsp_vec2_x,
   output logic signed [WORD_BITS-1:0]      rsp_vec2_y,
   output logic signed [WORD_BITS-1:0]      rsp_vec2_z,
   input  wire logic                        csr_we,
   input  wire logic [1:0]                  csr_addr,
   input  wire logic [WORD_BITS-2:0]        csr_wdata
);

   localparam int INNER_BITS = (WORD_BITS + 4 > 62) ? 62 : WORD_BITS + 4;
   localparam int ROT_FRAC   = (VECTOR_FRACTION_BITS > 60) ? 60 : VECTOR_FRACTION_BITS;
   localparam int VEC_BITS   = (ROT_FRAC + 2 > INNER_BITS) ? ROT_FRAC + 2 : INNER_BITS;
   localparam int VSH        = VECTOR_FRACTION_BITS - ROT_FRAC;
   localparam logic [63:0]  ONE_R = 64'd1 << ROT_FRAC;
   localparam logic [127:0] ONE2  = 128'd1 << (2 * ROT_FRAC);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SWEEP = 7'b0000010,
      ST_ISSUE = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_PAIR  = 7'b0010000,
      ST_SORT  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef enum logic [4:0] {
      SP_SQ0, SP_SQ1, SP_SQ2, SP_SQRT_T, SP_DIV12,
      SP_HH2, SP_AA, SP_SQ_D, SP_DIV_T, SP_TT, SP_SQ_C, SP_DIV_C, SP_SM, SP_TAU, SP_HH,
      SP_M1, SP_M2, SP_M3, SP_M4
   } step_type;

   typedef logic signed [INNER_BITS-1:0] inner_type;
   typedef logic signed [VEC_BITS-1:0]   vecw_type;

   state_type   state_ff, state_in;
   step_type    step_ff, step_in;
   logic [8:0]  sweep_ff, sweep_in;
   logic [1:0]  pr_ff, pr_in, mi_ff, mi_in;
   logic        srt_ff, srt_in, neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] wrk_ff, wrk_in, thr_ff, thr_in, tm_ff, tm_in, c_ff, c_in;
   logic [63:0] sm_ff, sm_in, tau_ff, tau_in;
   inner_type   tmp_ff, tmp_in, xn_ff, xn_in;
   inner_type   dg_ff [3];
   inner_type   dg_in [3];
   inner_type   off_ff [3];
   inner_type   off_in [3];
   vecw_type    vec_ff [3][3];
   vecw_type    vec_in [3][3];
   logic [7:0]  max_ff;
   logic [WORD_BITS-2:0] cnv_ff, flr_ff;

   sje_pkg::alu_req_type alu_req;
   logic [127:0] alu_a, alu_res;
   logic [63:0]  alu_b;
   logic         alu_done;

   logic [1:0]  pi, qi, xo, yo, vj, mn;
   logic signed [63:0] a_s, h_s, g_s, hv_s, tmp_s, mr, hx, yn;
   logic [63:0] ua, uh;
   logic        neg_c, mr_neg;

   sje_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .opa   (alu_a),
      .opb   (alu_b),
      .res   (alu_res),
      .done  (alu_done)
   );

   always_comb begin
      pi = (pr_ff == 2'd2) ? 2'd1 : 2'd0;
      qi = (pr_ff == 2'd0) ? 2'd1 : 2'd2;
      xo = (pr_ff == 2'd0) ? 2'd1 : 2'd0;
      yo = (pr_ff == 2'd2) ? 2'd1 : 2'd2;
      vj = mi_ff - 2'd1;
      case (pr_ff)
         2'd0:    a_s = 64'(off_ff[0]);
         2'd1:    a_s = 64'(off_ff[1]);
         default: a_s = 64'(off_ff[2]);
      endcase
      h_s   = 64'(dg_ff[qi]) - 64'(dg_ff[pi]);
      ua    = sje_pkg::mag64(a_s);
      uh    = sje_pkg::mag64(h_s);
      neg_c = (h_s != 64'sd0) && (h_s[63] != a_s[63]);
      if (mi_ff == 2'd0) begin
         g_s  = 64'(off_ff[xo]);
         hv_s = 64'(off_ff[yo]);
      end else begin
         g_s  = 64'(vec_ff[pi][vj]);
         hv_s = 64'(vec_ff[qi][vj]);
      end
      tmp_s = 64'(tmp_ff);
   end

   always_comb begin
      alu_req.start = (state_ff == ST_ISSUE);
      alu_req.op    = sje_pkg::ALU_MUL;
      alu_a         = '0;
      alu_b         = '0;
      mr_neg        = 1'b0;
      case (step_ff)
         SP_SQ0: begin
            alu_a = {64'd0, sje_pkg::mag64(64'(off_ff[0]))};
            alu_b = alu_a[63:0];
         end
         SP_SQ1: begin
            alu_a = {64'd0, sje_pkg::mag64(64'(off_ff[1]))};
            alu_b = alu_a[63:0];
         end
         SP_SQ2: begin
            alu_a = {64'd0, sje_pkg::mag64(64'(off_ff[2]))};
            alu_b = alu_a[63:0];
         end
         SP_SQRT_T, SP_SQ_D, SP_SQ_C: begin
            alu_req.op = sje_pkg::ALU_SQRT;
            alu_a      = acc_ff;
         end
         SP_DIV12: begin
            alu_a = {64'd0, wrk_ff};
            alu_b = sje_pkg::RECIP12;
         end
         SP_HH2: begin
            alu_a = {64'd0, uh};
            alu_b = uh;
         end
         SP_AA: begin
            alu_a = {64'd0, ua << 1};
            alu_b = ua << 1;
         end
         SP_DIV_T: begin
            alu_req.op = sje_pkg::ALU_DIV;
            alu_a      = {64'd0, ua << 1} << ROT_FRAC;
            alu_b      = wrk_ff;
         end
         SP_TT: begin
            alu_a = {64'd0, tm_ff};
            alu_b = tm_ff;
         end
         SP_DIV_C: begin
            alu_req.op = sje_pkg::ALU_DIV;
            alu_a      = ONE2;
            alu_b      = wrk_ff;
         end
         SP_SM: begin
            alu_a = {64'd0, tm_ff};
            alu_b = c_ff;
         end
         SP_TAU: begin
            alu_req.op = sje_pkg::ALU_DIV;
            alu_a      = {64'd0, sm_ff} << ROT_FRAC;
            alu_b      = ONE_R + c_ff;
         end
         SP_HH: begin
            alu_a  = {64'd0, tm_ff};
            alu_b  = ua;
            mr_neg = neg_c ^ a_s[63];
         end
         SP_M1: begin
            alu_a  = {64'd0, sje_pkg::mag64(g_s)};
            alu_b  = tau_ff;
            mr_neg = g_s[63] ^ neg_ff;
         end
         SP_M3: begin
            alu_a  = {64'd0, sje_pkg::mag64(hv_s)};
            alu_b  = tau_ff;
            mr_neg = hv_s[63] ^ neg_ff;
         end
         default: begin
            alu_a  = {64'd0, sm_ff};
            alu_b  = sje_pkg::mag64(tmp_s);
            mr_neg = neg_ff ^ tmp_s[63];
         end
      endcase
      mr = sje_pkg::mulr_fin(alu_res, mr_neg, ROT_FRAC);
      hx = sje_pkg::sat_w(hv_s + mr, INNER_BITS);
      yn = sje_pkg::sat_w(hv_s + mr, INNER_BITS);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sweep_in = sweep_ff;
      pr_in    = pr_ff;
      mi_in    = mi_ff;
      srt_in   = srt_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      wrk_in   = wrk_ff;
      thr_in   = thr_ff;
      tm_in    = tm_ff;
      c_in     = c_ff;
      sm_in    = sm_ff;
      tau_in   = tau_ff;
      tmp_in   = tmp_ff;
      xn_in    = xn_ff;
      dg_in    = dg_ff;
      off_in   = off_ff;
      vec_in   = vec_ff;
      mn       = 2'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dg_in[0]  = INNER_BITS'(sje_pkg::sat_w(64'(req_a_xx), INNER_BITS));
               dg_in[1]  = INNER_BITS'(sje_pkg::sat_w(64'(req_a_yy), INNER_BITS));
               dg_in[2]  = INNER_BITS'(sje_pkg::sat_w(64'(req_a_zz), INNER_BITS));
               off_in[0] = INNER_BITS'(sje_pkg::sat_w(64'(req_a_xy), INNER_BITS));
               off_in[1] = INNER_BITS'(sje_pkg::sat_w(64'(req_a_xz), INNER_BITS));
               off_in[2] = INNER_BITS'(sje_pkg::sat_w(64'(req_a_yz), INNER_BITS));
               for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                     vec_in[i][j] = (i == j) ? VEC_BITS'(ONE_R) : '0;
                  end
               end
               sweep_in = 9'd1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            srt_in = 1'b0;
            if (sweep_ff > {1'b0, max_ff}) begin
               state_in = ST_SORT;
            end else begin
               step_in  = SP_SQ0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (alu_done) begin
               state_in = ST_ISSUE;
               case (step_ff)
                  SP_SQ0: begin
                     acc_in  = alu_res;
                     step_in = SP_SQ1;
                  end
                  SP_SQ1: begin
                     acc_in  = acc_ff + alu_res;
                     step_in = SP_SQ2;
                  end
                  SP_SQ2: begin
                     acc_in  = acc_ff + alu_res;
                     step_in = SP_SQRT_T;
                  end
                  SP_SQRT_T: begin
                     wrk_in  = alu_res[63:0];
                     step_in = SP_DIV12;
                  end
                  SP_DIV12: begin
                     thr_in = 64'(alu_res[127:sje_pkg::RECIP12_SH]);
                     pr_in  = 2'd0;
                     srt_in = 1'b0;
                     if (64'(alu_res[127:sje_pkg::RECIP12_SH]) < 64'(cnv_ff))
                        state_in = ST_SORT;
                     else state_in = ST_PAIR;
                  end
                  SP_HH2: begin
                     acc_in  = alu_res;
                     step_in = SP_AA;
                  end
                  SP_AA: begin
                     acc_in  = acc_ff + alu_res;
                     step_in = SP_SQ_D;
                  end
                  SP_SQ_D: begin
                     wrk_in  = uh + alu_res[63:0];
                     step_in = SP_DIV_T;
                  end
                  SP_DIV_T: begin
                     tm_in   = alu_res[63:0];
                     step_in = SP_TT;
                  end
                  SP_TT: begin
                     acc_in  = ONE2 + alu_res;
                     step_in = SP_SQ_C;
                  end
                  SP_SQ_C: begin
                     wrk_in  = alu_res[63:0];
                     step_in = SP_DIV_C;
                  end
                  SP_DIV_C: begin
                     c_in    = alu_res[63:0];
                     step_in = SP_SM;
                  end
                  SP_SM: begin
                     sm_in   = 64'(mr);
                     step_in = SP_TAU;
                  end
                  SP_TAU: begin
                     tau_in  = alu_res[63:0];
                     step_in = SP_HH;
                  end
                  SP_HH: begin
                     dg_in[pi] = INNER_BITS'(sje_pkg::sat_w(64'(dg_ff[pi]) - mr, INNER_BITS));
                     dg_in[qi] = INNER_BITS'(sje_pkg::sat_w(64'(dg_ff[qi]) + mr, INNER_BITS));
                     off_in[pr_ff] = '0;
                     neg_in  = neg_c;
                     mi_in   = 2'd0;
                     step_in = SP_M1;
                  end
                  SP_M1: begin
                     tmp_in  = INNER_BITS'(hx);
                     step_in = SP_M2;
                  end
                  SP_M2: begin
                     xn_in   = INNER_BITS'(sje_pkg::sat_w(g_s - mr, INNER_BITS));
                     step_in = SP_M3;
                  end
                  SP_M3: begin
                     tmp_in  = INNER_BITS'(sje_pkg::sat_w(g_s - mr, INNER_BITS));
                     step_in = SP_M4;
                  end
                  default: begin
                     if (mi_ff == 2'd0) begin
                        off_in[xo] = xn_ff;
                        off_in[yo] = INNER_BITS'(yn);
                     end else begin
                        vec_in[pi][vj] = VEC_BITS'(xn_ff);
                        vec_in[qi][vj] = VEC_BITS'(INNER_BITS'(yn));
                     end
                     if (mi_ff == 2'd3) begin
                        pr_in    = pr_ff + 2'd1;
                        state_in = ST_PAIR;
                     end else begin
                        mi_in   = mi_ff + 2'd1;
                        step_in = SP_M1;
                     end
                  end
               endcase
            end
         end
         ST_PAIR: begin
            if (pr_ff == 2'd3) begin
               sweep_in = sweep_ff + 9'd1;
               state_in = ST_SWEEP;
            end else if (a_s != 64'sd0 && ua >= thr_ff) begin
               step_in  = SP_HH2;
               state_in = ST_ISSUE;
            end else begin
               pr_in = pr_ff + 2'd1;
            end
         end
         ST_SORT: begin
            if (!srt_ff) begin
               mn = 2'd0;
               if (dg_ff[1] < dg_ff[0]) mn = 2'd1;
               if (dg_ff[2] < dg_ff[mn]) mn = 2'd2;
            end else begin
               mn = 2'd1;
               if (dg_ff[2] < dg_ff[1]) mn = 2'd2;
            end
            dg_in[{1'b0, srt_ff}] = dg_ff[mn];
            dg_in[mn]             = dg_ff[{1'b0, srt_ff}];
            for (int j = 0; j < 3; j++) begin
               vec_in[{1'b0, srt_ff}][j] = vec_ff[mn][j];
               vec_in[mn][j]             = vec_ff[{1'b0, srt_ff}][j];
            end
            srt_in = 1'b1;
            if (srt_ff) state_in = ST_OUT;
         end
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff   <= sje_pkg::MAX_SWEEPS_RST;
         cnv_ff   <= (WORD_BITS-1)'(1);
         flr_ff   <= (WORD_BITS-1)'(1);
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               sje_pkg::CSR_MAX_SWEEPS: max_ff <= csr_wdata[7:0];
               sje_pkg::CSR_CONVERGE:   cnv_ff <= csr_wdata;
               sje_pkg::CSR_FLOOR:      flr_ff <= csr_wdata;
               default:                 ;
            endcase
         end
      end
      step_ff  <= step_in;
      sweep_ff <= sweep_in;
      pr_ff    <= pr_in;
      mi_ff    <= mi_in;
      srt_ff   <= srt_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      wrk_ff   <= wrk_in;
      thr_ff   <= thr_in;
      tm_ff    <= tm_in;
      c_ff     <= c_in;
      sm_ff    <= sm_in;
      tau_ff   <= tau_in;
      tmp_ff   <= tmp_in;
      xn_ff    <= xn_in;
      dg_ff    <= dg_in;
      off_ff   <= off_in;
      vec_ff   <= vec_in;
   end

   function automatic logic signed [WORD_BITS-1:0] lam_out(input inner_type d,
                                                          input logic [WORD_BITS-2:0] f);
      logic signed [63:0] v;
      v = 64'(d);
      if (v < $signed(64'(f))) v = 64'sd1 <<< VALUE_FRACTION_BITS;
      return WORD_BITS'(sje_pkg::sat_w(v, WORD_BITS));
   endfunction

   function automatic logic signed [WORD_BITS-1:0] vec_out(input vecw_type x);
      return WORD_BITS'(sje_pkg::sat_w(64'(x) <<< VSH, WORD_BITS));
   endfunction

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT);
   assign rsp_lambda_0 = lam_out(dg_ff[0], flr_ff);
   assign rsp_lambda_1 = lam_out(dg_ff[1], flr_ff);
   assign rsp_lambda_2 = lam_out(dg_ff[2], flr_ff);
   assign rsp_vec0_x   = vec_out(vec_ff[0][0]);
   assign rsp_vec0_y   = vec_out(vec_ff[0][1]);
   assign rsp_vec0_z   = vec_out(vec_ff[0][2]);
   assign rsp_vec1_x   = vec_out(vec_ff[1][0]);
   assign rsp_vec1_y   = vec_out(vec_ff[1][1]);
   assign rsp_vec1_z   = vec_out(vec_ff[1][2]);
   assign rsp_vec2_x   = vec_out(vec_ff[2][0]);
   assign rsp_vec2_y   = vec_out(vec_ff[2][1]);
   assign rsp_vec2_z   = vec_out(vec_ff[2][2]);

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after response");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid)) else $error("request not taken");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == ST_WAIT)) else $error("unit result not awaited");

endmodule
`default_nettype wire

[tb/sv/symmetric_3x3_jacobi_eigen_checker.sv]
`default_nettype none
module symmetric_3x3_jacobi_eigen_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [31:0] req_a_xx,
   input  wire logic signed [31:0] req_a_yy,
   input  wire logic signed [31:0] req_a_zz,
   input  wire logic signed [31:0] req_a_xy,
   input  wire logic signed [31:0] req_a_xz,
   input  wire logic signed [31:0] req_a_yz,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_lambda_0,
   input  wire logic signed [31:0] rsp_lambda_1,
   input  wire logic signed [31:0] rsp_lambda_2,
   input  wire logic signed [31:0] rsp_vec0_x,
   input  wire logic signed [31:0] rsp_vec0_y,
   input  wire logic signed [31:0] rsp_vec0_z,
   input  wire logic signed [31:0] rsp_vec1_x,
   input  wire logic signed [31:0] rsp_vec1_y,
   input  wire logic signed [31:0] rsp_vec1_z,
   input  wire logic signed [31:0] rsp_vec2_x,
   input  wire logic signed [31:0] rsp_vec2_y,
   input  wire logic signed [31:0] rsp_vec2_z,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_addr,
   input  wire logic [30:0]        csr_wdata,
   output int                      errors,
   output int                      pending,
   output int                      checked
);

   localparam int INNER = 36;
   localparam int RFRAC = 30;
   localparam int VFRAC = 24;

   typedef struct {
      logic signed [31:0] f[12];
   } eigen_result_type;

   eigen_result_type eigen_q[$];

   logic [7:0]  sweeps_lim;
   logic [30:0] conv_lim;
   logic [30:0] floor_lim;

   longint dg[3];
   longint off[3];
   longint vm[3][3];

   function automatic logic [63:0] magn(input longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint signed_of(input logic [63:0] m, input bit neg);
      if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint mul_round(input longint a, input longint b, input int sh);
      logic [127:0] p;
      p = {64'd0, magn(a)} * {64'd0, magn(b)};
      if (sh > 0) p = p + (128'd1 << (sh - 1));
      p = p >> sh;
      return signed_of(p[127:64] != 64'd0 ? '1 : p[63:0], (a < 0) != (b < 0));
   endfunction

   function automatic longint clamp(input longint x, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   function automatic logic [63:0] root(input logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] quot(input logic [127:0] n, input logic [63:0] d);
      logic [127:0] q;
      if (d == 64'd0) return '1;
      q = n / {64'd0, d};
      return q[127:64] != 64'd0 ? '1 : q[63:0];
   endfunction

   task automatic mix(inout longint x, inout longint y, input longint s, input longint tau);
      longint g;
      longint h;
      g = x;
      h = y;
      x = clamp(g - mul_round(s, clamp(h + mul_round(g, tau, RFRAC), INNER), RFRAC), INNER);
      y = clamp(h + mul_round(s, clamp(g - mul_round(h, tau, RFRAC), INNER), RFRAC), INNER);
   endtask

   task automatic rotate_pair(input int p, input int q);
      int           k;
      int           o;
      longint       a;
      longint       h;
      longint       t;
      longint       s;
      longint       tau;
      longint       hh;
      logic [63:0]  ua;
      logic [63:0]  uh;
      logic [63:0]  den;
      logic [63:0]  tm;
      logic [63:0]  c;
      logic [63:0]  sm;
      logic [63:0]  taum;
      bit           neg;
      logic [127:0] one2;
      k = 3 - p - q;
      o = p + q - 1;
      a = off[o];
      h = dg[q] - dg[p];
      ua = magn(a);
      uh = magn(h);
      neg = (h != 0) && ((h < 0) != (a < 0));
      one2 = 128'd1 << (2 * RFRAC);
      den = uh + root({64'd0, uh} * {64'd0, uh} + {64'd0, ua << 1} * {64'd0, ua << 1});
      tm = quot({64'd0, ua << 1} << RFRAC, den);
      c = quot(one2, root(one2 + {64'd0, tm} * {64'd0, tm}));
      sm = 64'(mul_round(longint'(tm), longint'(c), RFRAC));
      taum = quot({64'd0, sm} << RFRAC, (64'd1 << RFRAC) + c);
      t = signed_of(tm, neg);
      s = signed_of(sm, neg);
      tau = signed_of(taum, neg);
      hh = mul_round(t, a, RFRAC);
      dg[p] = clamp(dg[p] - hh, INNER);
      dg[q] = clamp(dg[q] + hh, INNER);
      off[o] = 0;
      mix(off[k + p - 1], off[k + q - 1], s, tau);
      for (int j = 0; j < 3; j++) mix(vm[p][j], vm[q][j], s, tau);
   endtask

   task automatic decompose(input longint m[6], output eigen_result_type r);
      logic [127:0] sq;
      logic [63:0]  thresh;
      longint       tmp;
      int           mi;
      for (int i = 0; i < 3; i++) begin
         dg[i] = m[i];
         off[i] = m[3 + i];
         for (int j = 0; j < 3; j++) vm[i][j] = (i == j) ? (longint'(1) << RFRAC) : 0;
      end
      for (int sw = 1; sw <= int'(sweeps_lim); sw++) begin
         sq = '0;
         for (int i = 0; i < 3; i++) sq = sq + {64'd0, magn(off[i])} * {64'd0, magn(off[i])};
         thresh = root(sq) / 64'(sje_pkg::DIV12);
         if (thresh < 64'(conv_lim)) break;
         for (int p = 0; p < 2; p++)
            for (int q = p + 1; q < 3; q++)
               if (off[p + q - 1] != 0 && magn(off[p + q - 1]) >= thresh) rotate_pair(p, q);
      end
      for (int i = 0; i < 2; i++) begin
         mi = i;
         for (int j = i + 1; j < 3; j++) if (dg[j] < dg[mi]) mi = j;
         if (mi != i) begin
            tmp = dg[mi]; dg[mi] = dg[i]; dg[i] = tmp;
            for (int j = 0; j < 3; j++) begin
               tmp = vm[mi][j]; vm[mi][j] = vm[i][j]; vm[i][j] = tmp;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (dg[i] < longint'(floor_lim)) dg[i] = longint'(1) << VFRAC;
         r.f[i] = 32'(clamp(dg[i], 32));
         for (int j = 0; j < 3; j++) r.f[3 + 3 * i + j] = 32'(clamp(mul_round(vm[i][j], 1, 0), 32));
      end
   endtask

   always @(posedge clock) begin
      longint           m[6];
      eigen_result_type e;
      eigen_result_type got;
      int               bad;
      bad = 0;
      if (reset) begin
         sweeps_lim <= sje_pkg::MAX_SWEEPS_RST;
         conv_lim <= 31'd1;
         floor_lim <= 31'd1;
         errors <= 0;
         pending <= 0;
         checked <= 0;
         eigen_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               sje_pkg::CSR_MAX_SWEEPS: sweeps_lim <= csr_wdata[7:0];
               sje_pkg::CSR_CONVERGE:   conv_lim <= csr_wdata;
               sje_pkg::CSR_FLOOR:      floor_lim <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            m = '{req_a_xx, req_a_yy, req_a_zz, req_a_xy, req_a_xz, req_a_yz};
            decompose(m, e);
            eigen_q.push_back(e);
         end
         if (rsp_valid) begin
            got.f = '{rsp_lambda_0, rsp_lambda_1, rsp_lambda_2,
                      rsp_vec0_x, rsp_vec0_y, rsp_vec0_z, rsp_vec1_x, rsp_vec1_y,
                      rsp_vec1_z, rsp_vec2_x, rsp_vec2_y, rsp_vec2_z};
            if (eigen_q.size() == 0) begin
               $display("%0t: unexpected response", $time);
               bad = 1;
            end else begin
               e = eigen_q.pop_front();
               checked <= checked + 1;
               for (int i = 0; i < 12; i++)
                  if (got.f[i] !== e.f[i]) begin
                     $display("%0t: field %0d expected %0d actual %0d", $time, i, e.f[i],
                              got.f[i]);
                     bad++;
                  end
            end
         end
         errors <= errors + bad;
         pending <= eigen_q.size();
      end
   end

endmodule
`default_nettype wire

[tb/sv/symmetric_3x3_jacobi_eigen_tb.sv]
`default_nettype none
module symmetric_3x3_jacobi_eigen_tb;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic signed [31:0] ONE = 32'sh0100_0000;
   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_a_xx, req_a_yy, req_a_zz, req_a_xy, req_a_xz, req_a_yz;
   logic               rsp_valid;
   logic signed [31:0] rsp_lambda_0, rsp_lambda_1, rsp_lambda_2;
   logic signed [31:0] rsp_vec0_x, rsp_vec0_y, rsp_vec0_z;
   logic signed [31:0] rsp_vec1_x, rsp_vec1_y, rsp_vec1_z;
   logic signed [31:0] rsp_vec2_x, rsp_vec2_y, rsp_vec2_z;
   logic               csr_we;
   logic [1:0]         csr_addr;
   logic [30:0]        csr_wdata;
   int                 errors, pending, checked;
   int                 n_sent, n_settings;

   symmetric_3x3_jacobi_eigen uut (.*);
   symmetric_3x3_jacobi_eigen_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(64'd8_000_000_000);
      $display("status: fail");
      $finish;
   end

   task automatic send_matrix(input logic signed [31:0] m[6]);
      int g;
      int r;
      start <= 1'b1;
      req_a_xx <= m[0]; req_a_yy <= m[1]; req_a_zz <= m[2];
      req_a_xy <= m[3]; req_a_xz <= m[4]; req_a_yz <= m[5];
      do @(negedge clock); while (busy);
      @(posedge clock);
      n_sent++;
      r = $urandom_range(0, 99);
      g = r < 60 ? 0 : (r < 90 ? $urandom_range(1, 4) : $urandom_range(10, 80));
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (busy || pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [30:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] sw, input logic [30:0] cv, input logic [30:0] fl);
      write_csr(sje_pkg::CSR_MAX_SWEEPS, {23'd0, sw});
      write_csr(sje_pkg::CSR_CONVERGE, cv);
      write_csr(sje_pkg::CSR_FLOOR, fl);
      n_settings++;
   endtask

   function automatic logic signed [31:0] pick_entry(input int kind);
      logic signed [31:0] ext[5];
      ext = '{MINV, MAXV, 32'sd0, -32'sd1, 32'sd1};
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
         default: return ext[$urandom_range(0, 4)];
      endcase
   endfunction

   task automatic random_matrix();
      logic signed [31:0] m[6];
      int kind;
      int shape;
      kind = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) m[i] = pick_entry(kind);
      if (shape == 0) begin
         m[3] = 0; m[4] = 0; m[5] = 0;
      end else if (shape == 1) begin
         m[3 + $urandom_range(0, 2)] = 0;
      end else if (shape == 2) begin
         m[1] = m[0];
      end
      send_matrix(m);
   endtask

   initial begin
      logic [7:0]  sw;
      logic [30:0] cv;
      logic [30:0] fl;
      reset = 1'b1;
      start = 1'b0;
      req_a_xx = '0; req_a_yy = '0; req_a_zz = '0;
      req_a_xy = '0; req_a_xz = '0; req_a_yz = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      n_sent = 0;
      n_settings = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_matrix('{0, 0, 0, 0, 0, 0});
      send_matrix('{ONE, ONE, ONE, 0, 0, 0});
      send_matrix('{3 * ONE, ONE, 2 * ONE, 0, 0, 0});
      send_matrix('{2 * ONE, 2 * ONE, 2 * ONE, ONE, 0, 0});
      send_matrix('{ONE, 2 * ONE, 3 * ONE, ONE / 2, ONE / 4, ONE / 8});
      send_matrix('{-ONE, -2 * ONE, 4 * ONE, ONE, -ONE, ONE});
      send_matrix('{0, 0, 0, 1, 1, 1});
      send_matrix('{0, 0, 0, -1, 0, 1});
      send_matrix('{ONE, ONE, ONE, 12, 0, 0});
      send_matrix('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
      send_matrix('{MINV, MINV, MINV, MINV, MINV, MINV});
      send_matrix('{MAXV, MINV, 0, MAXV, MINV, -1});
      send_matrix('{MINV, MAXV, -1, MINV, MAXV, 1});
      send_matrix('{0, 0, 0, MAXV, 0, 0});
      send_matrix('{ONE, -ONE, 0, 0, 0, MINV});
      send_matrix('{5 * ONE, 5 * ONE, -3 * ONE, 0, 2 * ONE, 0});
      send_matrix('{-32'sd5, 32'sd7, 32'sd3, -32'sd2, 32'sd9, -32'sd4});
      settle();

      set_regs(8'd0, 31'd1, 31'd0);
      write_csr(CSR_SPARE, '1);
      send_matrix('{3 * ONE, -ONE, 2 * ONE, ONE, ONE, ONE});
      send_matrix('{MINV, MAXV, 0, MAXV, MAXV, MAXV});
      settle();

      set_regs(8'd255, 31'd0, '1);
      send_matrix('{2 * ONE, -ONE, ONE, 0, 0, 0});
      send_matrix('{ONE, 2 * ONE, 0, ONE / 2, 0, 0});
      settle();

      set_regs(8'd1, '1, 31'd1);
      send_matrix('{ONE, 0, 0, MAXV, MINV, MAXV});
      settle();

      for (int ph = 0; ph < 12; ph++) begin
         sw = $urandom_range(0, 9) == 0 ? 8'd255 : 8'($urandom_range(1, 5));
         case ($urandom_range(0, 3))
            0: cv = 31'($urandom);
            1: cv = 31'($urandom_range(1, 32'h0010_0000));
            2: cv = 31'($urandom_range(1, 64));
            default: cv = 31'd1;
         endcase
         case ($urandom_range(0, 3))
            0: fl = 31'($urandom);
            1: fl = 31'($urandom_range(0, 32'h0400_0000));
            2: fl = 31'd0;
            default: fl = '1;
         endcase
         set_regs(sw, cv, fl);
         if (ph % 4 == 0) write_csr(CSR_SPARE, 31'($urandom));
         for (int i = 0; i < 105; i++) random_matrix();
         settle();
      end

      settle();
      repeat (200) @(posedge clock);
      $display("sent %0d requests under %0d register settings, %0d responses checked",
               n_sent, n_settings, checked);
      if (errors == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
